// File: rtl/lik_pkg.sv
// ----------------------------------------------------------------------------
// lik_pkg
// Shared types, constants and the arctangent table for the leg inverse
// kinematics pipeline.
// ----------------------------------------------------------------------------
package lik_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 8;
    localparam int CORDIC_STAGES_DEF   = 16;

    localparam int TAB_FRAC   = 20;
    localparam int PRESCALE_W = 24;
    localparam int CIW        = 32;
    localparam int ZW         = 29;
    localparam int XW         = CIW + PRESCALE_W + 2;
    localparam int OFF_SHIFT  = TAB_FRAC - 8;

    localparam int SQ_XZ_W   = 16;
    localparam int SQ_B_W    = 16;
    localparam int SQ_ACOS_W = 31;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int LEN_W     = 14;
    localparam int DEG_W     = 8;
    localparam int DEG_MAX   = 180;

    localparam logic signed [ZW-1:0] DEG90_T  = ZW'(90 * (1 << TAB_FRAC));
    localparam logic signed [ZW-1:0] DEG180_T = ZW'(180 * (1 << TAB_FRAC));

    localparam logic [LEN_W-1:0] COXA_LEN_RST = LEN_W'(480);
    localparam logic [LEN_W-1:0] MAIN_LEN_RST = LEN_W'(1280);
    localparam logic [LEN_W-1:0] DIAG_LEN_RST = LEN_W'(1920);
    localparam logic [DEG_W-1:0] BASE_RST     = DEG_W'(90);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COXA_LENGTH  = 3'd0,
        REG_MAIN_LENGTH  = 3'd1,
        REG_DIAG_LENGTH  = 3'd2,
        REG_TIBIA_OFFSET = 3'd3,
        REG_COXA_BASE    = 3'd4,
        REG_FEMUR_BASE   = 3'd5,
        REG_TIBIA_BASE   = 3'd6,
        REG_RIGHT_SIDE   = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_UNREACH = 2'd1,
        STATUS_SAT     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SP_NONE = 2'd0,
        SP_POS  = 2'd1,
        SP_NEG  = 2'd2,
        SP_ZERO = 2'd3
    } cordic_sp_t;

    typedef struct packed {
        logic hi;
        logic lo;
        logic neg;
    } acos_flag_t;

    function automatic logic signed [ZW-1:0] atan_tab(input int unsigned i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = ZW'(47185920);
            1:       v = ZW'(27855475);
            2:       v = ZW'(14718068);
            3:       v = ZW'(7471121);
            4:       v = ZW'(3750058);
            5:       v = ZW'(1876857);
            6:       v = ZW'(938658);
            7:       v = ZW'(469357);
            8:       v = ZW'(234682);
            9:       v = ZW'(117342);
            10:      v = ZW'(58671);
            11:      v = ZW'(29335);
            12:      v = ZW'(14668);
            13:      v = ZW'(7334);
            14:      v = ZW'(3667);
            15:      v = ZW'(1833);
            16:      v = ZW'(917);
            17:      v = ZW'(458);
            18:      v = ZW'(229);
            19:      v = ZW'(115);
            20:      v = ZW'(57);
            21:      v = ZW'(29);
            22:      v = ZW'(14);
            23:      v = ZW'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/lik_sqrt.sv
// ----------------------------------------------------------------------------
// lik_sqrt
// Pipelined integer square root, floor result, one root bit per stage.
// ----------------------------------------------------------------------------
module lik_sqrt #(
    parameter int RW = 16
) (
    input  logic            clk,
    input  logic [2*RW-1:0] radicand,
    output logic [RW-1:0]   root
);

    localparam int VW = 2 * RW + 1;

    logic [VW-1:0] rem_reg [0:RW-2];
    logic [RW-1:0] q_reg   [0:RW-1];

    for (genvar k = 0; k < RW; k++)
    begin : g_bit
        localparam int B = RW - 1 - k;
        logic [VW-1:0] rem_in;
        logic [VW-1:0] trial;
        logic [RW-1:0] q_in;
        logic          fit;

        if (k == 0)
        begin : g_first
            assign rem_in = VW'(radicand);
            assign q_in   = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign trial = (VW'(q_in) << (B + 1)) + (VW'(1) << (2 * B));
        assign fit   = rem_in >= trial;

        always_ff @(posedge clk)
        begin
            q_reg[k] <= fit ? (q_in | (RW'(1) << B)) : q_in;
        end

        if (k < RW - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= fit ? (rem_in - trial) : rem_in;
            end
        end
    end

    assign root = q_reg[RW-1];

endmodule

// File: rtl/lik_cordic.sv
// ----------------------------------------------------------------------------
// lik_cordic
// Pipelined vectoring CORDIC: atan(num/den) in 2^-20 degree, one
// rotation per stage after a setup stage.
// ----------------------------------------------------------------------------
module lik_cordic #(
    parameter int STAGES = lik_pkg::CORDIC_STAGES_DEF
) (
    input  logic                           clk,
    input  logic signed [lik_pkg::CIW-1:0] num,
    input  logic signed [lik_pkg::CIW-1:0] den,
    output logic signed [lik_pkg::ZW-1:0]  angle
);

    localparam int XW = lik_pkg::XW;
    localparam int ZW = lik_pkg::ZW;

    logic signed [XW-1:0]  x_reg  [0:STAGES-1];
    logic signed [XW-1:0]  y_reg  [0:STAGES-1];
    logic signed [ZW-1:0]  z_reg  [0:STAGES];
    lik_pkg::cordic_sp_t   sp_reg [0:STAGES];

    logic signed [lik_pkg::CIW-1:0] xs;
    logic signed [lik_pkg::CIW-1:0] ys;
    lik_pkg::cordic_sp_t            sp_next;

    always_comb
    begin
        xs = den[lik_pkg::CIW-1] ? -den : den;
        ys = den[lik_pkg::CIW-1] ? -num : num;
        if (den != '0)
            sp_next = lik_pkg::SP_NONE;
        else if (num[lik_pkg::CIW-1])
            sp_next = lik_pkg::SP_NEG;
        else if (num != '0)
            sp_next = lik_pkg::SP_POS;
        else
            sp_next = lik_pkg::SP_ZERO;
    end

    always_ff @(posedge clk)
    begin
        x_reg[0]  <= XW'(xs) <<< lik_pkg::PRESCALE_W;
        y_reg[0]  <= XW'(ys) <<< lik_pkg::PRESCALE_W;
        z_reg[0]  <= '0;
        sp_reg[0] <= sp_next;
    end

    for (genvar k = 0; k < STAGES; k++)
    begin : g_rot
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic                 up;

        assign dx = y_reg[k] >>> k;
        assign dy = x_reg[k] >>> k;
        assign up = !y_reg[k][XW-1];

        always_ff @(posedge clk)
        begin
            z_reg[k+1]  <= up ? z_reg[k] + lik_pkg::atan_tab(k)
                              : z_reg[k] - lik_pkg::atan_tab(k);
            sp_reg[k+1] <= sp_reg[k];
        end

        if (k < STAGES - 1)
        begin : g_xy
            always_ff @(posedge clk)
            begin
                x_reg[k+1] <= up ? x_reg[k] + dx : x_reg[k] - dx;
                y_reg[k+1] <= up ? y_reg[k] - dy : y_reg[k] + dy;
            end
        end
    end

    always_comb
    begin
        case (sp_reg[STAGES])
            lik_pkg::SP_POS:  angle = lik_pkg::DEG90_T;
            lik_pkg::SP_NEG:  angle = -lik_pkg::DEG90_T;
            lik_pkg::SP_ZERO: angle = '0;
            default:          angle = z_reg[STAGES];
        endcase
    end

endmodule

// File: rtl/leg_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// leg_inverse_kinematics
// Three-joint leg inverse kinematics: foot target to coxa, femur and tibia
// servo commands in whole degrees, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  request   start / busy         pos_x, pos_y, pos_z
//  result    done (one cycle)     coxa_angle, femur_angle, tibia_angle, status
//  config    cfg_write            cfg_index, cfg_data
//
//  One request per cycle; busy stays low. Each result passes in series
//  through three square root pipelines (16, 16 and 31 stages) and one
//  CORDIC pass.
//  Reset clears the valid line and loads the register defaults.
//  The receiver cannot stall, so nothing in the pipeline ever holds.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics #(
    parameter int ANGLE_FRAC_BITS = lik_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = lik_pkg::CORDIC_STAGES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [15:0]                 pos_x,
    input  logic signed [15:0]                 pos_y,
    input  logic signed [15:0]                 pos_z,
    input  logic                               cfg_write,
    input  logic [lik_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lik_pkg::CFG_W-1:0]          cfg_data,
    output logic                               done,
    output logic [lik_pkg::DEG_W-1:0]          coxa_angle,
    output logic [lik_pkg::DEG_W-1:0]          femur_angle,
    output logic [lik_pkg::DEG_W-1:0]          tibia_angle,
    output logic [1:0]                         status
);

    localparam int AF  = ANGLE_FRAC_BITS;
    localparam int C   = CORDIC_STAGES;
    localparam int RSH = lik_pkg::TAB_FRAC - AF;
    localparam int AW  = AF + 12;
    localparam int ZW  = lik_pkg::ZW;
    localparam int CIW = lik_pkg::CIW;
    localparam int LW  = lik_pkg::LEN_W;
    localparam int DW  = lik_pkg::DEG_W;

    localparam int ST_IN   = 1;
    localparam int ST_SXZ  = 3;
    localparam int ST_R2   = ST_SXZ + lik_pkg::SQ_XZ_W + 1;
    localparam int ST_B2   = ST_R2 + 2;
    localparam int ST_NT   = ST_B2 + 1;
    localparam int ST_DF   = ST_B2 + lik_pkg::SQ_B_W + 1;
    localparam int ST_PREP = ST_DF + 1;
    localparam int ST_DIFF = ST_PREP + 2;
    localparam int ST_S    = ST_DIFF + lik_pkg::SQ_ACOS_W;
    localparam int ST_ACOS = ST_S + 1 + C;
    localparam int LAT     = ST_ACOS + 5;

    localparam int N_A = ST_R2 - 1 - ST_SXZ;
    localparam int N_B = ST_DF - 1 - ST_NT;
    localparam int N_C = ST_S - ST_PREP;
    localparam int N_D = ST_ACOS - ST_PREP;
    localparam int N_E = ST_ACOS - (ST_IN + 1 + C);
    localparam int N_F = ST_ACOS - (ST_R2 + 1 + C);
    localparam int N_G = ST_ACOS - ST_R2;

    localparam logic signed [AW-1:0] F180 = AW'(180 * (1 << AF));
    localparam logic signed [AW-1:0] F90  = AW'(90 * (1 << AF));

    typedef struct packed {
        logic signed [15:0] y;
        logic [31:0]        yy;
    } line_a_t;

    typedef struct packed {
        logic signed [33:0] nf;
        logic signed [33:0] nt;
    } line_b_t;

    typedef struct packed {
        logic [30:0] an_f;
        logic [30:0] an_t;
    } line_c_t;

    typedef struct packed {
        lik_pkg::acos_flag_t fl_f;
        lik_pkg::acos_flag_t fl_t;
        logic                unreach;
    } line_d_t;

    function automatic logic signed [AW-1:0] to_frac(input logic signed [ZW-1:0] v);
        logic [ZW-1:0] mag;
        logic [ZW-1:0] rnd;
        mag = v[ZW-1] ? ZW'(-v) : ZW'(v);
        rnd = (mag + ZW'(1 << (RSH - 1))) >> RSH;
        return v[ZW-1] ? -AW'(rnd) : AW'(rnd);
    endfunction

    function automatic logic [DW:0] to_deg(input logic signed [AW-1:0] v);
        logic [AW-1:0] mag;
        logic [AW-1:0] rnd;
        mag = v[AW-1] ? AW'(-v) : AW'(v);
        rnd = (mag + AW'(1 << (AF - 1))) >> AF;
        if (v[AW-1] && rnd != '0)
            return {1'b1, DW'(0)};
        else if (!v[AW-1] && rnd > AW'(lik_pkg::DEG_MAX))
            return {1'b1, DW'(lik_pkg::DEG_MAX)};
        else
            return {1'b0, rnd[DW-1:0]};
    endfunction

    // configuration
    logic [LW-1:0]        cfg_coxa_len_reg;
    logic [LW-1:0]        cfg_main_len_reg;
    logic [LW-1:0]        cfg_diag_len_reg;
    logic signed [15:0]   cfg_off_reg;
    logic [DW-1:0]        cfg_cb_reg;
    logic [DW-1:0]        cfg_fb_reg;
    logic [DW-1:0]        cfg_tb_reg;
    logic                 cfg_right_reg;
    logic [2*LW-1:0]      k_mm_reg;
    logic [2*LW-1:0]      k_dd_reg;
    logic [30:0]          k_dt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_coxa_len_reg <= lik_pkg::COXA_LEN_RST;
            cfg_main_len_reg <= lik_pkg::MAIN_LEN_RST;
            cfg_diag_len_reg <= lik_pkg::DIAG_LEN_RST;
            cfg_off_reg      <= '0;
            cfg_cb_reg       <= lik_pkg::BASE_RST;
            cfg_fb_reg       <= lik_pkg::BASE_RST;
            cfg_tb_reg       <= lik_pkg::BASE_RST;
            cfg_right_reg    <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (lik_pkg::reg_index_t'(cfg_index))
                lik_pkg::REG_COXA_LENGTH:  cfg_coxa_len_reg <= cfg_data[LW-1:0];
                lik_pkg::REG_MAIN_LENGTH:  cfg_main_len_reg <= cfg_data[LW-1:0];
                lik_pkg::REG_DIAG_LENGTH:  cfg_diag_len_reg <= cfg_data[LW-1:0];
                lik_pkg::REG_TIBIA_OFFSET: cfg_off_reg      <= signed'(cfg_data);
                lik_pkg::REG_COXA_BASE:    cfg_cb_reg       <= cfg_data[DW-1:0];
                lik_pkg::REG_FEMUR_BASE:   cfg_fb_reg       <= cfg_data[DW-1:0];
                lik_pkg::REG_TIBIA_BASE:   cfg_tb_reg       <= cfg_data[DW-1:0];
                lik_pkg::REG_RIGHT_SIDE:   cfg_right_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        k_mm_reg <= (2*LW)'(cfg_main_len_reg) * (2*LW)'(cfg_main_len_reg);
        k_dd_reg <= (2*LW)'(cfg_diag_len_reg) * (2*LW)'(cfg_diag_len_reg);
        k_dt_reg <= {31'((2*LW)'(cfg_main_len_reg) * (2*LW)'(cfg_diag_len_reg)) << 1};
    end

    // valid line
    logic [LAT:1] v_reg;
    logic         accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= {v_reg[LAT-1:1], accept};
    end

    assign done = v_reg[LAT];

    // request, squares, x-z reach
    logic signed [15:0] s1_x_reg;
    logic signed [15:0] s1_y_reg;
    logic signed [15:0] s1_z_reg;
    logic [31:0]        s2_xx_reg;
    logic [31:0]        s2_zz_reg;
    logic [31:0]        s2_yy_reg;
    logic signed [15:0] s2_y_reg;
    logic [31:0]        s3_sxz_reg;
    line_a_t            s3_a_reg;
    logic signed [31:0] xx_w;
    logic signed [31:0] zz_w;
    logic signed [31:0] yy_w;

    assign xx_w = 32'(s1_x_reg) * 32'(s1_x_reg);
    assign zz_w = 32'(s1_z_reg) * 32'(s1_z_reg);
    assign yy_w = 32'(s1_y_reg) * 32'(s1_y_reg);

    always_ff @(posedge clk)
    begin
        s1_x_reg   <= pos_x;
        s1_y_reg   <= pos_y;
        s1_z_reg   <= pos_z;
        s2_xx_reg  <= unsigned'(xx_w);
        s2_zz_reg  <= unsigned'(zz_w);
        s2_yy_reg  <= unsigned'(yy_w);
        s2_y_reg   <= s1_y_reg;
        s3_sxz_reg <= s2_xx_reg + s2_zz_reg;
        s3_a_reg   <= '{y: s2_y_reg, yy: s2_yy_reg};
    end

    logic [lik_pkg::SQ_XZ_W-1:0] q_xz;

    lik_sqrt #(.RW(lik_pkg::SQ_XZ_W)) u_sqrt_xz (
        .clk      (clk),
        .radicand (s3_sxz_reg),
        .root     (q_xz)
    );

    line_a_t d_a_reg [0:N_A-1];

    always_ff @(posedge clk)
    begin
        d_a_reg[0] <= s3_a_reg;
        for (int i = 1; i < N_A; i++)
        begin
            d_a_reg[i] <= d_a_reg[i-1];
        end
    end

    // planar reach and target distance
    logic signed [16:0] s20_r2_reg;
    logic signed [15:0] s20_y_reg;
    logic [31:0]        s20_yy_reg;
    logic [31:0]        s21_r2sq_reg;
    logic [31:0]        s21_yy_reg;
    logic [31:0]        s22_b2_reg;
    logic signed [33:0] r2sq_w;
    logic signed [33:0] nf_w;
    logic signed [33:0] nt_w;
    line_b_t            s23_b_reg;

    assign r2sq_w = 34'(s20_r2_reg) * 34'(s20_r2_reg);
    assign nf_w   = signed'({6'd0, k_mm_reg}) + signed'({2'd0, s22_b2_reg})
                  - signed'({6'd0, k_dd_reg});
    assign nt_w   = signed'({6'd0, k_mm_reg}) + signed'({6'd0, k_dd_reg})
                  - signed'({2'd0, s22_b2_reg});

    always_ff @(posedge clk)
    begin
        s20_r2_reg   <= signed'({1'b0, q_xz}) - signed'({3'd0, cfg_coxa_len_reg});
        s20_y_reg    <= d_a_reg[N_A-1].y;
        s20_yy_reg   <= d_a_reg[N_A-1].yy;
        s21_r2sq_reg <= r2sq_w[31:0];
        s21_yy_reg   <= s20_yy_reg;
        s22_b2_reg   <= s21_r2sq_reg + s21_yy_reg;
        s23_b_reg    <= '{nf: nf_w, nt: nt_w};
    end

    logic [lik_pkg::SQ_B_W-1:0] b_w;

    lik_sqrt #(.RW(lik_pkg::SQ_B_W)) u_sqrt_b (
        .clk      (clk),
        .radicand (s22_b2_reg),
        .root     (b_w)
    );

    line_b_t d_b_reg [0:N_B-1];

    always_ff @(posedge clk)
    begin
        d_b_reg[0] <= s23_b_reg;
        for (int i = 1; i < N_B; i++)
        begin
            d_b_reg[i] <= d_b_reg[i-1];
        end
    end

    // law of cosines denominators and range checks
    logic [30:0]        s39_df_reg;
    logic signed [33:0] s39_nf_reg;
    logic signed [33:0] s39_nt_reg;
    logic [29:0]        mb_w;

    assign mb_w = 30'(cfg_main_len_reg) * 30'(b_w);

    always_ff @(posedge clk)
    begin
        s39_df_reg <= {mb_w, 1'b0};
        s39_nf_reg <= d_b_reg[N_B-1].nf;
        s39_nt_reg <= d_b_reg[N_B-1].nt;
    end

    logic signed [33:0]  df_s;
    logic signed [33:0]  dt_s;
    logic signed [33:0]  anf_w;
    logic signed [33:0]  ant_w;
    lik_pkg::acos_flag_t fl_f_w;
    lik_pkg::acos_flag_t fl_t_w;
    logic                unreach_w;

    always_comb
    begin
        df_s       = signed'({3'd0, s39_df_reg});
        dt_s       = signed'({3'd0, k_dt_reg});
        fl_f_w.hi  = s39_nf_reg >= df_s;
        fl_f_w.lo  = s39_nf_reg <= -df_s;
        fl_f_w.neg = s39_nf_reg[33];
        fl_t_w.hi  = s39_nt_reg >= dt_s;
        fl_t_w.lo  = s39_nt_reg <= -dt_s;
        fl_t_w.neg = s39_nt_reg[33];
        anf_w      = (fl_f_w.hi || fl_f_w.lo) ? '0
                   : (fl_f_w.neg ? -s39_nf_reg : s39_nf_reg);
        ant_w      = (fl_t_w.hi || fl_t_w.lo) ? '0
                   : (fl_t_w.neg ? -s39_nt_reg : s39_nt_reg);
        unreach_w  = (s39_df_reg == '0) || (k_dt_reg == '0)
                  || (s39_nf_reg > df_s) || (s39_nf_reg < -df_s)
                  || (s39_nt_reg > dt_s) || (s39_nt_reg < -dt_s);
    end

    logic [30:0] s40_df_reg;
    logic [30:0] s40_dt_reg;
    line_c_t     s40_c_reg;
    line_d_t     s40_d_reg;
    logic [61:0] s41_ddf_reg;
    logic [61:0] s41_nnf_reg;
    logic [61:0] s41_ddt_reg;
    logic [61:0] s41_nnt_reg;
    logic [61:0] s42_rf_reg;
    logic [61:0] s42_rt_reg;

    always_ff @(posedge clk)
    begin
        s40_df_reg  <= s39_df_reg;
        s40_dt_reg  <= k_dt_reg;
        s40_c_reg   <= '{an_f: anf_w[30:0], an_t: ant_w[30:0]};
        s40_d_reg   <= '{fl_f: fl_f_w, fl_t: fl_t_w, unreach: unreach_w};
        s41_ddf_reg <= 62'(s40_df_reg) * 62'(s40_df_reg);
        s41_nnf_reg <= 62'(s40_c_reg.an_f) * 62'(s40_c_reg.an_f);
        s41_ddt_reg <= 62'(s40_dt_reg) * 62'(s40_dt_reg);
        s41_nnt_reg <= 62'(s40_c_reg.an_t) * 62'(s40_c_reg.an_t);
        s42_rf_reg  <= s41_ddf_reg - s41_nnf_reg;
        s42_rt_reg  <= s41_ddt_reg - s41_nnt_reg;
    end

    logic [lik_pkg::SQ_ACOS_W-1:0] s_f;
    logic [lik_pkg::SQ_ACOS_W-1:0] s_t;

    lik_sqrt #(.RW(lik_pkg::SQ_ACOS_W)) u_sqrt_f (
        .clk      (clk),
        .radicand (s42_rf_reg),
        .root     (s_f)
    );

    lik_sqrt #(.RW(lik_pkg::SQ_ACOS_W)) u_sqrt_t (
        .clk      (clk),
        .radicand (s42_rt_reg),
        .root     (s_t)
    );

    line_c_t d_c_reg [0:N_C-1];
    line_d_t d_d_reg [0:N_D-1];

    always_ff @(posedge clk)
    begin
        d_c_reg[0] <= s40_c_reg;
        d_d_reg[0] <= s40_d_reg;
        for (int i = 1; i < N_C; i++)
        begin
            d_c_reg[i] <= d_c_reg[i-1];
        end
        for (int i = 1; i < N_D; i++)
        begin
            d_d_reg[i] <= d_d_reg[i-1];
        end
    end

    // arctangents
    logic signed [ZW-1:0] theta_w;
    logic signed [ZW-1:0] gamma_w;
    logic signed [ZW-1:0] atf_w;
    logic signed [ZW-1:0] att_w;

    lik_cordic #(.STAGES(C)) u_cordic_theta (
        .clk   (clk),
        .num   (CIW'(s1_z_reg)),
        .den   (CIW'(s1_x_reg)),
        .angle (theta_w)
    );

    lik_cordic #(.STAGES(C)) u_cordic_gamma (
        .clk   (clk),
        .num   (CIW'(s20_r2_reg)),
        .den   (CIW'(s20_y_reg)),
        .angle (gamma_w)
    );

    lik_cordic #(.STAGES(C)) u_cordic_f (
        .clk   (clk),
        .num   (signed'({1'b0, s_f})),
        .den   (signed'({1'b0, d_c_reg[N_C-1].an_f})),
        .angle (atf_w)
    );

    lik_cordic #(.STAGES(C)) u_cordic_t (
        .clk   (clk),
        .num   (signed'({1'b0, s_t})),
        .den   (signed'({1'b0, d_c_reg[N_C-1].an_t})),
        .angle (att_w)
    );

    logic signed [ZW-1:0] d_e_reg [0:N_E-1];
    logic signed [ZW-1:0] d_f_reg [0:N_F-1];
    logic                 d_g_reg [0:N_G-1];

    always_ff @(posedge clk)
    begin
        d_e_reg[0] <= theta_w;
        d_f_reg[0] <= gamma_w;
        d_g_reg[0] <= s20_y_reg[15];
        for (int i = 1; i < N_E; i++)
        begin
            d_e_reg[i] <= d_e_reg[i-1];
        end
        for (int i = 1; i < N_F; i++)
        begin
            d_f_reg[i] <= d_f_reg[i-1];
        end
        for (int i = 1; i < N_G; i++)
        begin
            d_g_reg[i] <= d_g_reg[i-1];
        end
    end

    // final angles and commands
    line_d_t              ld_w;
    logic signed [ZW-1:0] fem_w;
    logic signed [ZW-1:0] beta_w;

    assign ld_w = d_d_reg[N_D-1];

    always_comb
    begin
        if (ld_w.fl_f.hi)
            fem_w = '0;
        else if (ld_w.fl_f.lo)
            fem_w = lik_pkg::DEG180_T;
        else if (ld_w.fl_f.neg)
            fem_w = lik_pkg::DEG180_T - atf_w;
        else
            fem_w = atf_w;

        if (ld_w.fl_t.hi)
            beta_w = '0;
        else if (ld_w.fl_t.lo)
            beta_w = lik_pkg::DEG180_T;
        else if (ld_w.fl_t.neg)
            beta_w = lik_pkg::DEG180_T - att_w;
        else
            beta_w = att_w;
    end

    logic signed [ZW-1:0] f1_theta_reg;
    logic signed [ZW-1:0] f1_gamma_reg;
    logic signed [ZW-1:0] f1_fem_reg;
    logic signed [ZW-1:0] f1_beta_reg;
    logic                 f1_yneg_reg;
    logic                 f1_unreach_reg;
    logic signed [AW-1:0] f2_theta_reg;
    logic signed [AW-1:0] f2_gamma_reg;
    logic signed [AW-1:0] f2_fem_reg;
    logic signed [AW-1:0] f2_beta_reg;
    logic signed [AW-1:0] f2_off_reg;
    logic                 f2_yneg_reg;
    logic                 f2_unreach_reg;
    logic signed [AW-1:0] f3_cx_reg;
    logic signed [AW-1:0] f3_fm_reg;
    logic signed [AW-1:0] f3_tb_reg;
    logic                 f3_unreach_reg;
    logic signed [AW-1:0] f4_cx_reg;
    logic signed [AW-1:0] f4_fm_reg;
    logic signed [AW-1:0] f4_tb_reg;
    logic                 f4_unreach_reg;
    logic [DW:0]          cx_d;
    logic [DW:0]          fm_d;
    logic [DW:0]          tb_d;

    assign cx_d = to_deg(f4_cx_reg);
    assign fm_d = to_deg(f4_fm_reg);
    assign tb_d = to_deg(f4_tb_reg);

    always_ff @(posedge clk)
    begin
        f1_theta_reg   <= d_e_reg[N_E-1];
        f1_gamma_reg   <= d_f_reg[N_F-1];
        f1_fem_reg     <= fem_w;
        f1_beta_reg    <= beta_w;
        f1_yneg_reg    <= d_g_reg[N_G-1];
        f1_unreach_reg <= ld_w.unreach;

        f2_theta_reg   <= to_frac(f1_theta_reg);
        f2_gamma_reg   <= to_frac(f1_gamma_reg);
        f2_fem_reg     <= to_frac(f1_fem_reg);
        f2_beta_reg    <= to_frac(f1_beta_reg);
        f2_off_reg     <= to_frac(ZW'(cfg_off_reg) <<< lik_pkg::OFF_SHIFT);
        f2_yneg_reg    <= f1_yneg_reg;
        f2_unreach_reg <= f1_unreach_reg;

        f3_cx_reg      <= signed'(AW'(cfg_cb_reg) << AF) + f2_theta_reg;
        f3_fm_reg      <= (f2_yneg_reg ? AW'(0) : F180) - f2_gamma_reg - f2_fem_reg;
        f3_tb_reg      <= F90 - f2_beta_reg - f2_off_reg;
        f3_unreach_reg <= f2_unreach_reg;

        // mirror for a right leg, then add the neutral positions
        f4_cx_reg      <= f3_cx_reg;
        f4_fm_reg      <= (cfg_right_reg ? -f3_fm_reg : f3_fm_reg)
                        + signed'(AW'(cfg_fb_reg) << AF);
        f4_tb_reg      <= (cfg_right_reg ? -f3_tb_reg : f3_tb_reg)
                        + signed'(AW'(cfg_tb_reg) << AF);
        f4_unreach_reg <= f3_unreach_reg;

        coxa_angle     <= cx_d[DW-1:0];
        femur_angle    <= fm_d[DW-1:0];
        tibia_angle    <= tb_d[DW-1:0];
        if (f4_unreach_reg)
            status <= lik_pkg::STATUS_UNREACH;
        else if (cx_d[DW] || fm_d[DW] || tb_d[DW])
            status <= lik_pkg::STATUS_SAT;
        else
            status <= lik_pkg::STATUS_OK;
    end

endmodule

// File: dv/tb_leg_inverse_kinematics.sv
// ----------------------------------------------------------------------------
// tb_leg_inverse_kinematics
// Drives foot targets through the leg inverse kinematics pipeline under a
// series of register settings, takes each servo command and status word from
// an independent fixed-point model or a typed row; checks results in order.
// ----------------------------------------------------------------------------
module tb_leg_inverse_kinematics;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [lik_pkg::DEG_W-1:0] coxa;
        logic [lik_pkg::DEG_W-1:0] femur;
        logic [lik_pkg::DEG_W-1:0] tibia;
        lik_pkg::status_t          st;
    } joint_cmd_t;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        bit                 typed;
        joint_cmd_t         cmd;
    } target_row_t;

    localparam longint FRAC_ONE = 256;
    localparam longint D90      = 90 * 1048576;
    localparam longint D180     = 180 * 1048576;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              start = 1'b0;
    logic                              busy;
    logic signed [15:0]                pos_x = '0;
    logic signed [15:0]                pos_y = '0;
    logic signed [15:0]                pos_z = '0;
    logic                              cfg_write = 1'b0;
    logic [lik_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [lik_pkg::CFG_W-1:0]         cfg_data = '0;
    logic                              done;
    logic [lik_pkg::DEG_W-1:0]         coxa_angle;
    logic [lik_pkg::DEG_W-1:0]         femur_angle;
    logic [lik_pkg::DEG_W-1:0]         tibia_angle;
    logic [1:0]                        status;

    bit                                row_typed = 1'b0;
    joint_cmd_t                        row_cmd;

    logic [lik_pkg::LEN_W-1:0]         coxa_len = lik_pkg::COXA_LEN_RST;
    logic [lik_pkg::LEN_W-1:0]         main_len = lik_pkg::MAIN_LEN_RST;
    logic [lik_pkg::LEN_W-1:0]         diag_len = lik_pkg::DIAG_LEN_RST;
    logic signed [15:0]                tib_off  = '0;
    logic [lik_pkg::DEG_W-1:0]         coxa_bse = lik_pkg::BASE_RST;
    logic [lik_pkg::DEG_W-1:0]         femur_bse = lik_pkg::BASE_RST;
    logic [lik_pkg::DEG_W-1:0]         tibia_bse = lik_pkg::BASE_RST;
    logic                              right_leg = 1'b0;

    joint_cmd_t                        pending_cmds[$];
    int                                mismatches = 0;

    leg_inverse_kinematics uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .coxa_angle  (coxa_angle),
        .femur_angle (femur_angle),
        .tibia_angle (tibia_angle),
        .status      (status)
    );

    always #10 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint round_away(longint v, int s);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        m = (m + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint cordic_atan(longint num, longint den);
        longint xa;
        longint ya;
        longint za;
        longint dx;
        longint dy;
        za = 0;
        if (den == 0)
            return (num > 0) ? D90 : ((num < 0) ? -D90 : 0);
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        xa = den <<< 24;
        ya = num <<< 24;
        for (int i = 0; i < lik_pkg::CORDIC_STAGES_DEF; i++)
        begin
            dx = ya >>> i;
            dy = xa >>> i;
            if (ya >= 0)
            begin
                xa += dx;
                ya -= dy;
                za += longint'(lik_pkg::atan_tab(i));
            end
            else
            begin
                xa -= dx;
                ya += dy;
                za -= longint'(lik_pkg::atan_tab(i));
            end
        end
        return za;
    endfunction

    function automatic longint cordic_acos(longint num, longint den);
        longint s;
        if (num >= den)
            return 0;
        if (num <= -den)
            return D180;
        s = longint'(int_sqrt(den * den - num * num));
        if (num >= 0)
            return cordic_atan(s, num);
        return D180 - cordic_atan(s, -num);
    endfunction

    function automatic logic [lik_pkg::DEG_W-1:0] clamp_deg(longint v, inout bit sat);
        longint d;
        d = round_away(v, 8);
        if (d < 0)
        begin
            sat = 1'b1;
            return lik_pkg::DEG_W'(0);
        end
        if (d > lik_pkg::DEG_MAX)
        begin
            sat = 1'b1;
            return lik_pkg::DEG_W'(lik_pkg::DEG_MAX);
        end
        return d[lik_pkg::DEG_W-1:0];
    endfunction

    function automatic joint_cmd_t solve_leg(logic signed [15:0] px,
                                             logic signed [15:0] py,
                                             logic signed [15:0] pz);
        longint x, y, z, m, d, theta, reach, b2, b, gam, nf, df, nt, dt;
        longint fem, beta1, off, cx, fm, tb;
        bit unreach;
        bit sat;
        joint_cmd_t r;
        x = px;
        y = py;
        z = pz;
        m = main_len;
        d = diag_len;
        sat = 1'b0;
        theta = round_away(cordic_atan(z, x), 12);
        reach = longint'(int_sqrt(x * x + z * z)) - longint'(coxa_len);
        b2 = reach * reach + y * y;
        b = longint'(int_sqrt(b2));
        gam = round_away(cordic_atan(reach, y), 12);
        if (y < 0)
            gam += 180 * FRAC_ONE;
        nf = m * m + b2 - d * d;
        df = 2 * m * b;
        nt = m * m + d * d - b2;
        dt = 2 * d * m;
        unreach = df == 0 || dt == 0 || nf > df || -nf > df || nt > dt || -nt > dt;
        fem = round_away(cordic_acos(nf, df), 12);
        beta1 = round_away(cordic_acos(nt, dt), 12);
        off = round_away(longint'(tib_off) * 4096, 12);
        cx = longint'(coxa_bse) * FRAC_ONE + theta;
        fm = 180 * FRAC_ONE - (gam + fem);
        tb = 90 * FRAC_ONE - (beta1 + off);
        if (right_leg)
        begin
            fm = -fm;
            tb = -tb;
        end
        fm += longint'(femur_bse) * FRAC_ONE;
        tb += longint'(tibia_bse) * FRAC_ONE;
        r.coxa  = clamp_deg(cx, sat);
        r.femur = clamp_deg(fm, sat);
        r.tibia = clamp_deg(tb, sat);
        r.st    = unreach ? lik_pkg::STATUS_UNREACH
                : (sat ? lik_pkg::STATUS_SAT : lik_pkg::STATUS_OK);
        return r;
    endfunction

    always @(posedge clk)
    begin
        joint_cmd_t want;
        if (done)
        begin
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d %0d %0d %0d",
                             coxa_angle, femur_angle, tibia_angle, status);
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (want.coxa !== coxa_angle || want.femur !== femur_angle ||
                    want.tibia !== tibia_angle || want.st !== status)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 want.coxa, want.femur, want.tibia, want.st,
                                 coxa_angle, femur_angle, tibia_angle, status);
                end
            end
        end
        if (start && !busy)
            pending_cmds.push_back(row_typed ? row_cmd : solve_leg(pos_x, pos_y, pos_z));
    end

    task automatic write_reg(lik_pkg::reg_index_t idx, logic [lik_pkg::CFG_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            lik_pkg::REG_COXA_LENGTH:  coxa_len  = val[lik_pkg::LEN_W-1:0];
            lik_pkg::REG_MAIN_LENGTH:  main_len  = val[lik_pkg::LEN_W-1:0];
            lik_pkg::REG_DIAG_LENGTH:  diag_len  = val[lik_pkg::LEN_W-1:0];
            lik_pkg::REG_TIBIA_OFFSET: tib_off   = val;
            lik_pkg::REG_COXA_BASE:    coxa_bse  = val[lik_pkg::DEG_W-1:0];
            lik_pkg::REG_FEMUR_BASE:   femur_bse = val[lik_pkg::DEG_W-1:0];
            lik_pkg::REG_TIBIA_BASE:   tibia_bse = val[lik_pkg::DEG_W-1:0];
            default:                   right_leg = val[0];
        endcase
        @(negedge clk);
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_leg(int cl, int ml, int dl, int off, int cb, int fb, int tb, int rs);
        write_reg(lik_pkg::REG_COXA_LENGTH, lik_pkg::CFG_W'(cl));
        write_reg(lik_pkg::REG_MAIN_LENGTH, lik_pkg::CFG_W'(ml));
        write_reg(lik_pkg::REG_DIAG_LENGTH, lik_pkg::CFG_W'(dl));
        write_reg(lik_pkg::REG_TIBIA_OFFSET, lik_pkg::CFG_W'(off));
        write_reg(lik_pkg::REG_COXA_BASE, lik_pkg::CFG_W'(cb));
        write_reg(lik_pkg::REG_FEMUR_BASE, lik_pkg::CFG_W'(fb));
        write_reg(lik_pkg::REG_TIBIA_BASE, lik_pkg::CFG_W'(tb));
        write_reg(lik_pkg::REG_RIGHT_SIDE, lik_pkg::CFG_W'(rs));
        cfg_write <= 1'b0;
    endtask

    task automatic send_target(logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z, bit typed, joint_cmd_t cmd);
        int gap;
        start     <= 1'b1;
        pos_x     <= x;
        pos_y     <= y;
        pos_z     <= z;
        row_typed <= typed;
        row_cmd   <= cmd;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        gap = ($urandom_range(0, 99) < 60) ? 0 :
              ($urandom_range(0, 99) < 95) ? $urandom_range(1, 4) : $urandom_range(20, 150);
        if (gap != 0)
        begin
            start     <= 1'b0;
            row_typed <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic random_targets(int count);
        int span;
        logic signed [15:0] x, y, z;
        span = int'(coxa_len) + int'(main_len) + int'(diag_len);
        if (span > 32767)
            span = 32767;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                x = 16'($urandom);
                y = 16'($urandom);
                z = 16'($urandom);
            end
            else
            begin
                x = 16'($urandom_range(0, 2 * span) - span);
                y = 16'($urandom_range(0, 2 * span) - span);
                z = 16'($urandom_range(0, 2 * span) - span);
            end
            send_target(x, y, z, 1'b0, '0);
            if (i == count / 2 && $urandom_range(0, 1) == 0)
            begin
                start <= 1'b0;
                drain();
            end
        end
        start <= 1'b0;
    endtask

    target_row_t rows[] = '{
        '{16'sd0,      16'sd0,      16'sd0,      1'b1,
          '{8'd90, 8'd180, 8'd180, lik_pkg::STATUS_UNREACH}},
        '{16'sd1800,   -16'sd800,   16'sd0,      1'b0, '0},
        '{16'sd1500,   16'sd900,    16'sd700,    1'b0, '0},
        '{16'sd0,      -16'sd1000,  16'sd2000,   1'b0, '0},
        '{16'sd0,      -16'sd1000,  -16'sd2000,  1'b0, '0},
        '{16'sd2200,   16'sd0,      16'sd0,      1'b0, '0},
        '{16'sd200,    16'sd0,      16'sd0,      1'b0, '0},
        '{16'sd480,    16'sd0,      16'sd0,      1'b0, '0},
        '{16'sd480,    16'sd1500,   16'sd0,      1'b0, '0},
        '{-16'sd1800,  -16'sd900,   16'sd300,    1'b0, '0},
        '{-16'sd1800,  -16'sd900,   -16'sd300,   1'b0, '0},
        '{16'sd32767,  16'sd32767,  16'sd32767,  1'b0, '0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
        '{16'sd32767,  -16'sd32768, 16'sd0,      1'b0, '0},
        '{-16'sd32768, 16'sd0,      16'sd32767,  1'b0, '0},
        '{16'sd1,      16'sd1,      -16'sd1,     1'b0, '0},
        '{-16'sd1,     -16'sd1,     16'sd1,      1'b0, '0},
        '{16'sd1000,   -16'sd3000,  16'sd1000,   1'b0, '0},
        '{16'sd2600,   16'sd200,    -16'sd400,   1'b0, '0},
        '{16'sd5000,   16'sd5000,   16'sd5000,   1'b0, '0}
    };

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (rows[i])
            send_target(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].cmd);
        random_targets(200);
        drain();
        load_leg(1, 16383, 16383, -23040, 0, 0, 0, 1);
        foreach (rows[i])
            if (!rows[i].typed)
                send_target(rows[i].x, rows[i].y, rows[i].z, 1'b0, '0);
        random_targets(120);
        drain();
        load_leg(16383, 1, 1, 23040, 180, 180, 180, 0);
        random_targets(80);
        drain();
        load_leg(0, 0, 0, 0, 90, 90, 90, 1);
        random_targets(40);
        drain();
        for (int p = 0; p < 6; p++)
        begin
            load_leg($urandom_range(100, 1200), $urandom_range(600, 4000),
                     $urandom_range(600, 4000), $urandom_range(0, 46080) - 23040,
                     $urandom_range(0, 180), $urandom_range(0, 180),
                     $urandom_range(0, 180), $urandom_range(0, 1));
            random_targets(140);
            drain();
        end
        repeat (120) @(negedge clk);
        if (mismatches == 0 && pending_cmds.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/lik_pkg.sv
rtl/lik_sqrt.sv
rtl/lik_cordic.sv
rtl/leg_inverse_kinematics.sv
dv/tb_leg_inverse_kinematics.sv
